@@ rtl/core/quad_vertex_dedup_indexer_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef QUAD_VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH
`define QUAD_VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QVDI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qvdi assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QVDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qvdi assertion failed");

`endif

@@ rtl/core/qvdi_pkg.sv @@
`default_nettype none

package qvdi_pkg;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned IN_W     = 112;
  localparam int unsigned OUT_W    = 40;

  localparam logic [CNT_W-1:0] UNIQUE_SAT         = 17'd65536;
  localparam logic [CNT_W-1:0] VERTEX_SAT         = 17'd131071;
  localparam logic [CNT_W-1:0] MAX_INDEXED_UNIQUE = 17'd65535;

  // Vertex attributes, tex_u in the lowest bits.
  typedef struct packed {
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [31:0] rgba;
    logic [15:0] tex_v;
    logic [15:0] tex_u;
  } corner_t;

  // Passed from one corner cell to the next.
  typedef struct packed {
    logic             held;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } link_t;

endpackage

`default_nettype wire

@@ rtl/core/quad_vertex_dedup_indexer_unit.sv @@
`default_nettype none

// Vertex de-duplicating indexer: one vertex word in, one index word out, one
// word per cycle when not stalled. A row of GROUP_SIZE corner cells holds the
// distinct corners of the current quad; all cells compare the incoming vertex
// in the same cycle and the hit travels down the row, so the match and append
// path sets the cycle time. The result sits in a single output register; input
// is taken whenever that register is empty or being drained. On tlast the word
// carries mesh_indexed and all counters restart for the next mesh.
module quad_vertex_dedup_indexer_unit #(
  parameter int unsigned GROUP_SIZE  = 6,
  parameter int unsigned INDEX_LIMIT = 65536
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tex_u[15:0], tex_v[31:16], rgba[63:32], pos_x[79:64], pos_y[95:80], pos_z[111:96]
  input  wire  [qvdi_pkg::IN_W-1:0]    s_axis_tdata_i,
  input  wire                          s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // index[15:0], is_new[16], unique_count[33:17], mesh_indexed[34], zero[39:35]
  output logic [qvdi_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned SLOT_W = $clog2(GROUP_SIZE + 1);

  qvdi_pkg::corner_t          corner;
  qvdi_pkg::link_t            link [GROUP_SIZE+1];
  logic                       step;
  logic                       append;
  logic                       clear;
  logic [SLOT_W-1:0]          slot_q, slot_d, slot_after;
  logic [qvdi_pkg::IDX_W-1:0] next_idx_q, next_idx_d;
  logic [qvdi_pkg::CNT_W-1:0] unique_q, unique_d, unique_new;
  logic [qvdi_pkg::CNT_W-1:0] vertex_q, vertex_d, vertex_new;
  logic [qvdi_pkg::IDX_W-1:0] index;
  logic                       group_end;
  logic                       mesh_ok;
  logic                       out_valid_q;
  logic [qvdi_pkg::OUT_W-1:0] out_data_q;

  assign corner          = qvdi_pkg::corner_t'(s_axis_tdata_i);
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  assign link[0] = '{held: 1'b1, hit: 1'b0, idx: '0};

  for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_cell
    qvdi_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clear),
      .append_i (append),
      .corner_i (corner),
      .idx_i    (next_idx_q),
      .link_i   (link[g]),
      .link_o   (link[g+1])
    );
  end

  assign append     = step && !link[GROUP_SIZE].hit;
  assign slot_after = slot_q + 1'b1;
  assign group_end  = slot_after >= SLOT_W'(GROUP_SIZE);
  assign clear      = step && (s_axis_tlast_i || group_end);
  assign index      = link[GROUP_SIZE].hit ? link[GROUP_SIZE].idx : next_idx_q;

  always_comb begin
    unique_new = unique_q;
    if (!link[GROUP_SIZE].hit && unique_q < qvdi_pkg::UNIQUE_SAT) begin
      unique_new = unique_q + 1'b1;
    end
    vertex_new = vertex_q;
    if (vertex_q < qvdi_pkg::VERTEX_SAT) begin
      vertex_new = vertex_q + 1'b1;
    end
  end

  assign mesh_ok = s_axis_tlast_i && (slot_after == SLOT_W'(GROUP_SIZE))
                && (vertex_new <= qvdi_pkg::CNT_W'(INDEX_LIMIT))
                && (unique_new <= qvdi_pkg::MAX_INDEXED_UNIQUE);

  always_comb begin
    slot_d     = slot_q;
    next_idx_d = next_idx_q;
    unique_d   = unique_q;
    vertex_d   = vertex_q;
    if (step) begin
      if (s_axis_tlast_i) begin
        slot_d     = '0;
        next_idx_d = '0;
        unique_d   = '0;
        vertex_d   = '0;
      end else begin
        slot_d     = group_end ? '0 : slot_after;
        next_idx_d = append ? next_idx_q + 1'b1 : next_idx_q;
        unique_d   = unique_new;
        vertex_d   = vertex_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      next_idx_q  <= '0;
      unique_q    <= '0;
      vertex_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q     <= slot_d;
      next_idx_q <= next_idx_d;
      unique_q   <= unique_d;
      vertex_q   <= vertex_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {5'd0, mesh_ok, unique_new, !link[GROUP_SIZE].hit, index};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/qvdi_cell.sv @@
`default_nettype none

module qvdi_cell (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           clear_i,
  input  wire                           append_i,
  input  qvdi_pkg::corner_t             corner_i,
  input  wire  [qvdi_pkg::IDX_W-1:0]    idx_i,
  input  qvdi_pkg::link_t               link_i,
  output qvdi_pkg::link_t               link_o
);

  logic                       held_q, held_d;
  qvdi_pkg::corner_t          corner_q;
  logic [qvdi_pkg::IDX_W-1:0] idx_q;
  logic                       match;
  logic                       take;

  assign match = held_q && (corner_q == corner_i);
  // first free cell in the row takes a new corner
  assign take  = append_i && !held_q && link_i.held;

  always_comb begin
    link_o.held = held_q;
    link_o.hit  = link_i.hit | match;
    link_o.idx  = link_i.hit ? link_i.idx : idx_q;
  end

  always_comb begin
    held_d = held_q;
    if (clear_i) begin
      held_d = 1'b0;
    end else if (take) begin
      held_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      corner_q <= corner_i;
      idx_q    <= idx_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/qvdi_checker.sv @@
`default_nettype none

`include "quad_vertex_dedup_indexer_unit_assert.svh"

module qvdi_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        s_axis_tvalid_i,
  input wire                        s_axis_tready_o,
  input wire [qvdi_pkg::IN_W-1:0]   s_axis_tdata_i,
  input wire                        s_axis_tlast_i,
  input wire                        m_axis_tvalid_o,
  input wire                        m_axis_tready_i,
  input wire [qvdi_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  logic                       m_stall;
  logic                       m_is_new;
  logic                       m_indexed;
  logic [qvdi_pkg::CNT_W-1:0] m_count;
  logic                       m_count_ok;

  assign m_stall    = m_axis_tvalid_o && !m_axis_tready_i;
  assign m_is_new   = m_axis_tdata_o[16];
  assign m_count    = m_axis_tdata_o[33:17];
  assign m_indexed  = m_axis_tdata_o[34];
  assign m_count_ok = (m_count != '0) && (m_count <= qvdi_pkg::MAX_INDEXED_UNIQUE);

  `QVDI_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `QVDI_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o)
  `QVDI_ASSERT_SAME(a_indexed_count, m_axis_tvalid_o && m_indexed, m_count_ok)
  `QVDI_ASSERT_SAME(a_reuse_count, m_axis_tvalid_o && !m_is_new, m_count != '0)

endmodule

bind quad_vertex_dedup_indexer_unit qvdi_checker u_qvdi_checker (.*);

`default_nettype wire
